### hdl/chm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_pkg
// Shared widths, reset values, operation codes and sequencer states for the
// chained hash map.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int KEY_W          = 16;
  localparam int VAL_W          = 16;
  localparam int CAP_W          = 11;
  localparam int CAP_RESET      = 1024;
  localparam int POOL_NODES_DEF = 1024;
  localparam int BUCKETS_DEF    = 397;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_BUCKET,
    ST_HEAD,
    ST_HEAD_CHK,
    ST_NODE_CHK,
    ST_RESP
  } state_t;

endpackage

### hdl/chm_mod_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_mod_step
// Bucket index unit: one shared multiplier used in two passes to form
// key mod BUCKETS, first for the quotient, then for the remainder.
// ----------------------------------------------------------------------------
module chm_mod_step import chm_pkg::*; #(
  parameter int BUCKETS = BUCKETS_DEF
) (
  input  logic                                             sel_rem,
  input  logic [KEY_W-1:0]                                 key,
  input  logic [KEY_W-1:0]                                 quot_in,
  output logic [KEY_W-1:0]                                 quot_out,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] rem_out
);

  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  // reciprocal rounded up with KEY_W + BKT_W fraction bits: exact for any key
  localparam int SHIFT  = KEY_W + BKT_W;
  localparam int MUL_W  = KEY_W + 2;
  localparam int PROD_W = KEY_W + MUL_W;
  localparam logic [MUL_W-1:0] MUL_C =
    MUL_W'(((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS));
  localparam logic [MUL_W-1:0] BKT_C = MUL_W'(BUCKETS);

  logic [KEY_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic [PROD_W-1:0] prod;
  logic [KEY_W-1:0]  diff;

  // first pass: key times reciprocal; second pass: quotient times bucket count
  always_comb begin
    mul_a    = sel_rem ? quot_in : key;
    mul_b    = sel_rem ? BKT_C : MUL_C;
    prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
    quot_out = KEY_W'(prod >> SHIFT);
    diff     = key - prod[KEY_W-1:0];
    rem_out  = diff[BKT_W-1:0];
  end

endmodule

### hdl/chained_hash_map_fixed_pool.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map_fixed_pool
// Key-to-value map: hash table with separate chaining over a fixed node pool.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bucket head table to empty, one bucket a
// cycle, through all BUCKETS buckets (397 by default) with s_axis_tready low;
// capacity writes are taken throughout. Each request then runs alone: the
// bucket index key mod BUCKETS is formed by one shared multiplier in two
// passes (quotient by a reciprocal multiply, then multiply back and
// subtract), followed by one registered read of the head table and a step to
// link or check the head. A lookup then reads its chain one node at a time,
// since the node memory has a single read port. A result that cannot leave
// holds the block until the output register frees; once it sits there, a new
// request is taken while it waits.
// ----------------------------------------------------------------------------
module chained_hash_map_fixed_pool import chm_pkg::*; #(
  parameter int POOL_NODES = POOL_NODES_DEF,
  parameter int BUCKETS    = BUCKETS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,   // [15:0] line_key, [31:16] value_in
  input  logic [0:0]       s_axis_tuser,   // [0] opcode
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] value_out
  output logic [0:0]       m_axis_tuser,   // [0] ok
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int NODE_W = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int CNT_W  = $clog2(POOL_NODES + 1);
  localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  state_t state, state_next;

  logic [BKT_W-1:0]     clr_idx;
  logic [CNT_W-1:0]     count;
  logic [CAP_W-1:0]     capacity;

  op_t              op;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] val;
  logic [KEY_W-1:0] quot;
  logic [KEY_W-1:0] quot_next;
  logic [BKT_W-1:0] rem;
  logic [BKT_W-1:0] rem_next;
  logic             rem_sel;

  logic             res_load;
  logic             res_ok_d;
  logic [VAL_W-1:0] res_val_d;
  logic             res_ok;
  logic [VAL_W-1:0] res_val;

  logic             in_acc;
  logic             room;

  // memories: heads hold {valid, node}, links hold {valid, node}
  logic [NODE_W:0]    head_mem [BUCKETS];
  logic [KEY_W-1:0]   key_mem  [POOL_NODES];
  logic [VAL_W-1:0]   val_mem  [POOL_NODES];
  logic [NODE_W:0]    next_mem [POOL_NODES];

  logic               head_we;
  logic [BKT_W-1:0]   head_waddr;
  logic [NODE_W:0]    head_wdata;
  logic               head_re;
  logic [NODE_W:0]    head_q;

  logic               node_we;
  logic [NODE_W-1:0]  node_waddr;
  logic               node_re;
  logic [NODE_W-1:0]  node_raddr;
  logic [KEY_W-1:0]   key_q;
  logic [VAL_W-1:0]   val_q;
  logic [NODE_W:0]    next_q;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign node_waddr    = count[NODE_W-1:0];
  assign rem_sel       = (state == ST_BUCKET);

  // room left when the count is below both the capacity and the pool size
  assign room = (CMP_W'(count) < CMP_W'(capacity)) && (CMP_W'(count) < CMP_W'(POOL_NODES));

  // shared multiplier for the bucket index
  chm_mod_step #(
    .BUCKETS (BUCKETS)
  ) u_mod_step (
    .sel_rem  (rem_sel),
    .key      (key),
    .quot_in  (quot),
    .quot_out (quot_next),
    .rem_out  (rem_next)
  );

  // bucket head table
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (head_re) begin
      head_q <= head_mem[rem];
    end
  end

  // node pool
  always_ff @(posedge clk) begin
    if (node_we) begin
      key_mem[node_waddr]  <= key;
      val_mem[node_waddr]  <= val;
      next_mem[node_waddr] <= head_q;
    end
    if (node_re) begin
      key_q  <= key_mem[node_raddr];
      val_q  <= val_mem[node_raddr];
      next_q <= next_mem[node_raddr];
    end
  end

  // sequencer: next state, memory controls, result capture
  always_comb begin
    state_next = state;
    head_we    = 1'b0;
    head_waddr = rem;
    head_wdata = '0;
    head_re    = 1'b0;
    node_we    = 1'b0;
    node_re    = 1'b0;
    node_raddr = head_q[NODE_W-1:0];
    res_load   = 1'b0;
    res_ok_d   = 1'b0;
    res_val_d  = '0;
    case (state)
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_waddr = clr_idx;
        if (clr_idx == BKT_W'(BUCKETS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_HASH;
        end
      end
      ST_HASH: begin
        state_next = ST_BUCKET;
      end
      ST_BUCKET: begin
        state_next = ST_HEAD;
      end
      ST_HEAD: begin
        head_re    = 1'b1;
        state_next = ST_HEAD_CHK;
      end
      ST_HEAD_CHK: begin
        if (op == OP_INSERT) begin
          res_load   = 1'b1;
          res_ok_d   = room;
          state_next = ST_RESP;
          if (room) begin
            head_we    = 1'b1;
            head_wdata = {1'b1, node_waddr};
            node_we    = 1'b1;
          end
        end else if (head_q[NODE_W]) begin
          node_re    = 1'b1;
          state_next = ST_NODE_CHK;
        end else begin
          res_load   = 1'b1;
          state_next = ST_RESP;
        end
      end
      ST_NODE_CHK: begin
        if (key_q == key) begin
          res_load   = 1'b1;
          res_ok_d   = 1'b1;
          res_val_d  = val_q;
          state_next = ST_RESP;
        end else if (next_q[NODE_W]) begin
          node_re    = 1'b1;
          node_raddr = next_q[NODE_W-1:0];
        end else begin
          res_load   = 1'b1;
          state_next = ST_RESP;
        end
      end
      ST_RESP: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_idx       <= '0;
      count         <= '0;
      capacity      <= CAP_W'(CAP_RESET);
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (node_we) begin
        count <= count + 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (state == ST_RESP && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // payload: request fields, quotient, remainder, result and output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op  <= op_t'(s_axis_tuser[0]);
      key <= s_axis_tdata[15:0];
      val <= s_axis_tdata[31:16];
    end
    if (state == ST_HASH) begin
      quot <= quot_next;
    end
    if (state == ST_BUCKET) begin
      rem <= rem_next;
    end
    if (res_load) begin
      res_ok  <= res_ok_d;
      res_val <= res_val_d;
    end
    if (state == ST_RESP && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tuser[0] <= res_ok;
      m_axis_tdata    <= res_val;
    end
  end

endmodule

### hdl/chm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chm_checker
// Port-level checks on the chained hash map, bound to the top level.
// ----------------------------------------------------------------------------
module chm_checker import chm_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic [31:0]      s_axis_tdata,
  input logic [0:0]       s_axis_tuser,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [15:0]      m_axis_tdata,
  input logic [0:0]       m_axis_tuser,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [CAP_W-1:0] cfg_data
);

  logic [1:0] pend;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // track requests taken but not yet answered
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (in_acc && !out_acc) begin
      pend <= pend + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend <= pend - 1'b1;
    end
  end

  // the head table sweep holds requests off after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !s_axis_tready)
    else $error("request taken during the head table sweep");

  // a failed or absent result carries a zero value
  a_zero_on_fail: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("non-zero value on a failed result");

  // no result without an outstanding request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> pend != 2'd0)
    else $error("result with no outstanding request");

  // at most one request in work and one result waiting
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    pend == 2'd2 |-> !in_acc)
    else $error("request taken with a result and a request already pending");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

endmodule

bind chained_hash_map_fixed_pool chm_checker u_chm_checker (.*);
